// File: rtl/lpu_pkg.sv
// shared types, constants and helpers for the leapfrog particle update unit
package lpu_pkg;

  localparam int NUM_GROUPS_DEFAULT = 4;

  // register stages from request to result, result register included
  localparam int PIPE_DEPTH = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Q2.14 one
  localparam logic [15:0] LAMBDA_ONE = 16'h4000;

  localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
  localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TIME_STEP = 3'd0,
    CFG_TEMP_MODE = 3'd1,
    CFG_LAMBDA    = 3'd2,
    CFG_DIAG_X    = 3'd3,
    CFG_DIAG_Y    = 3'd4,
    CFG_DIAG_Z    = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    TEMP_NONE   = 2'd0,
    TEMP_SINGLE = 2'd1,
    TEMP_GROUP  = 2'd2
  } temp_mode_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [31:0]        inv_mass;
    logic [1:0]         coupling_group;
    logic               last_atom;
  } item_t;

  typedef struct packed {
    logic signed [31:0] old_pos_x;
    logic signed [31:0] old_pos_y;
    logic signed [31:0] old_pos_z;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               batch_end;
  } result_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: rtl/leapfrog_particle_update_unit.sv
// top level of the leapfrog particle update unit: an eight-stage fixed-point pipeline
//
// One particle per request, one request per clock. start is taken at every rising edge at
// which busy is low; busy is high only while rst is high. Each request comes back as one
// result, marked by result_valid for a single cycle, in request order.
// The pipeline depth is set by the multiply chain of the velocity step
// (inv_mass*dt, then force times that in two partial products, then new velocity times dt),
// one multiplier level per stage. There is no back-pressure: the receiver must take every
// result in the cycle it appears. Configuration writes take effect at the edge of the
// write and must only be made while no request is in flight.
module leapfrog_particle_update_unit #(
  parameter int NUM_GROUPS = lpu_pkg::NUM_GROUPS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // request side
  input  logic                             start,
  output logic                             busy,
  input  lpu_pkg::item_t                   item,
  // result side
  output logic                             result_valid,
  output lpu_pkg::result_t                 result,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [lpu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lpu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int Depth = lpu_pkg::PIPE_DEPTH;
  // widened so a group count of four still compares against a 2-bit group
  localparam logic [2:0] NumGroupsW = 3'(NUM_GROUPS);
  localparam logic [1:0] LastGroup  = 2'(NUM_GROUPS - 1);

  // configuration registers
  logic [23:0]        time_step;
  logic [1:0]         temp_mode;
  logic [63:0]        lambda_table;
  logic signed [31:0] diag [3];

  // request capture and valid chain
  logic             accept;
  logic [Depth-1:0] valid;

  // per-axis views of the request
  logic signed [31:0] in_x [3];
  logic signed [31:0] in_v [3];
  logic signed [31:0] in_f [3];
  logic [1:0]         grp;
  logic [15:0]        lambda;

  // stage 1: raw products
  logic signed [31:0] s1_x [3];
  logic signed [31:0] s1_f [3];
  logic signed [48:0] s1_sprod [3];
  logic signed [63:0] s1_pprod [3];
  logic [55:0]        s1_imdt;
  logic               s1_last;

  // stage 2: rounded scale and pressure terms, force partial products
  logic signed [31:0] s2_x [3];
  logic signed [34:0] s2_s [3];
  logic signed [33:0] s2_p [3];
  logic signed [60:0] s2_pa [3];
  logic signed [60:0] s2_pb [3];
  logic               s2_fneg [3];
  logic               s2_last;

  // stage 3: low partial product with rounding bias, scale minus pressure
  logic signed [31:0] s3_x [3];
  logic signed [35:0] s3_sp [3];
  logic signed [60:0] s3_pa [3];
  logic signed [60:0] s3_q [3];
  logic               s3_last;

  // stage 4: force term
  logic signed [31:0] s4_x [3];
  logic signed [35:0] s4_sp [3];
  logic signed [48:0] s4_a [3];
  logic               s4_last;

  // stage 5: new velocity
  logic signed [31:0] s5_x [3];
  logic signed [31:0] s5_vn [3];
  logic               s5_last;

  // stage 6: velocity times dt
  logic signed [31:0] s6_x [3];
  logic signed [31:0] s6_vn [3];
  logic signed [56:0] s6_vd [3];
  logic               s6_last;

  // stage 7: rounded displacement
  logic signed [31:0] s7_x [3];
  logic signed [31:0] s7_vn [3];
  logic signed [32:0] s7_r [3];
  logic               s7_last;

  // next values of the arithmetic stages
  logic signed [48:0] s_rnd [3];
  logic signed [63:0] p_rnd [3];
  logic signed [60:0] a_sum [3];
  logic signed [56:0] d_rnd [3];
  logic signed [34:0] s2_s_next [3];
  logic signed [33:0] s2_p_next [3];
  logic signed [60:0] s3_q_next [3];
  logic signed [48:0] s4_a_next [3];
  logic signed [31:0] s5_vn_next [3];
  logic signed [32:0] s7_r_next [3];
  logic signed [31:0] pos_next [3];

  // busy only shields requests from being lost while the pipe clears
  assign busy   = rst;
  assign accept = start && !busy;

  assign result_valid = valid[Depth-1];

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= '0;
      temp_mode    <= '0;
      lambda_table <= '0;
      diag[0]      <= '0;
      diag[1]      <= '0;
      diag[2]      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpu_pkg::CFG_TIME_STEP: time_step    <= cfg_data[23:0];
        lpu_pkg::CFG_TEMP_MODE: temp_mode    <= cfg_data[1:0];
        lpu_pkg::CFG_LAMBDA:    lambda_table <= cfg_data;
        lpu_pkg::CFG_DIAG_X:    diag[0]      <= cfg_data[31:0];
        lpu_pkg::CFG_DIAG_Y:    diag[1]      <= cfg_data[31:0];
        lpu_pkg::CFG_DIAG_Z:    diag[2]      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // valid bits walk alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Depth-2:0], accept};
    end
  end

  assign in_x[0] = item.pos_x;
  assign in_x[1] = item.pos_y;
  assign in_x[2] = item.pos_z;
  assign in_v[0] = item.vel_x;
  assign in_v[1] = item.vel_y;
  assign in_v[2] = item.vel_z;
  assign in_f[0] = item.force_x;
  assign in_f[1] = item.force_y;
  assign in_f[2] = item.force_z;

  // groups beyond the configured count fall onto the last one
  assign grp = ({1'b0, item.coupling_group} >= NumGroupsW) ? LastGroup : item.coupling_group;

  // scale factor; no scaling multiplies by exactly one, which rounds back to v
  always_comb begin
    unique case (temp_mode)
      lpu_pkg::TEMP_SINGLE: lambda = lambda_table[15:0];
      lpu_pkg::TEMP_GROUP:  lambda = lambda_table[16*grp +: 16];
      lpu_pkg::TEMP_NONE:   lambda = lpu_pkg::LAMBDA_ONE;
      default:              lambda = lpu_pkg::LAMBDA_ONE;
    endcase
  end

  // rounding everywhere is to nearest, ties away from zero:
  // (p + half - sign) >>> shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_rnd[i] = s1_sprod[i] + 49'sd8192 - 49'(s1_sprod[i][48]);
      s2_s_next[i] = s_rnd[i][48:14];
      p_rnd[i] = s1_pprod[i] + 64'sd536870912 - 64'(s1_pprod[i][63]);
      s2_p_next[i] = p_rnd[i][63:30];

      // bias for the 2^40 rounding rides on the low partial product;
      // the sign comes from the force since the low product can be zero
      s3_q_next[i] = s2_pb[i] + 61'sd549755813888 - 61'(s2_fneg[i]);

      a_sum[i] = s3_pa[i] + 61'(signed'(s3_q[i][60:28]));
      s4_a_next[i] = a_sum[i][60:12];

      s5_vn_next[i] = lpu_pkg::sat32(50'(s4_sp[i]) + 50'(s4_a[i]));

      d_rnd[i] = s6_vd[i] + 57'sd8388608 - 57'(s6_vd[i][56]);
      s7_r_next[i] = d_rnd[i][56:24];

      pos_next[i] = lpu_pkg::sat32(50'(s7_x[i]) + 50'(s7_r[i]));
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    // stage 1
    s1_imdt <= 56'(item.inv_mass) * 56'(time_step);
    s1_last <= item.last_atom;
    for (int i = 0; i < 3; i++) begin
      s1_x[i]     <= in_x[i];
      s1_f[i]     <= in_f[i];
      s1_sprod[i] <= 49'(in_v[i]) * 49'(signed'({1'b0, lambda}));
      s1_pprod[i] <= 64'(diag[i]) * 64'(in_v[i]);
    end

    // stage 2
    s2_last <= s1_last;
    for (int i = 0; i < 3; i++) begin
      s2_x[i]    <= s1_x[i];
      s2_s[i]    <= s2_s_next[i];
      s2_p[i]    <= s2_p_next[i];
      s2_pa[i]   <= 61'(s1_f[i]) * 61'(signed'({1'b0, s1_imdt[55:28]}));
      s2_pb[i]   <= 61'(s1_f[i]) * 61'(signed'({1'b0, s1_imdt[27:0]}));
      s2_fneg[i] <= s1_f[i][31];
    end

    // stage 3
    s3_last <= s2_last;
    for (int i = 0; i < 3; i++) begin
      s3_x[i]  <= s2_x[i];
      s3_sp[i] <= 36'(s2_s[i]) - 36'(s2_p[i]);
      s3_pa[i] <= s2_pa[i];
      s3_q[i]  <= s3_q_next[i];
    end

    // stage 4
    s4_last <= s3_last;
    for (int i = 0; i < 3; i++) begin
      s4_x[i]  <= s3_x[i];
      s4_sp[i] <= s3_sp[i];
      s4_a[i]  <= s4_a_next[i];
    end

    // stage 5
    s5_last <= s4_last;
    for (int i = 0; i < 3; i++) begin
      s5_x[i]  <= s4_x[i];
      s5_vn[i] <= s5_vn_next[i];
    end

    // stage 6
    s6_last <= s5_last;
    for (int i = 0; i < 3; i++) begin
      s6_x[i]  <= s5_x[i];
      s6_vn[i] <= s5_vn[i];
      s6_vd[i] <= 57'(s5_vn[i]) * 57'(signed'({1'b0, time_step}));
    end

    // stage 7
    s7_last <= s6_last;
    for (int i = 0; i < 3; i++) begin
      s7_x[i]  <= s6_x[i];
      s7_vn[i] <= s6_vn[i];
      s7_r[i]  <= s7_r_next[i];
    end

    // stage 8: result register
    result.old_pos_x <= s7_x[0];
    result.old_pos_y <= s7_x[1];
    result.old_pos_z <= s7_x[2];
    result.new_pos_x <= pos_next[0];
    result.new_pos_y <= pos_next[1];
    result.new_pos_z <= pos_next[2];
    result.new_vel_x <= s7_vn[0];
    result.new_vel_y <= s7_vn[1];
    result.new_vel_z <= s7_vn[2];
    result.batch_end <= s7_last;
  end

endmodule

// File: rtl/lpu_checker.sv
// port-level checks for the leapfrog particle update unit, bound to the top level
module lpu_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input lpu_pkg::item_t   item,
  input logic             result_valid,
  input lpu_pkg::result_t result
);

  // every request comes back after the fixed latency
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(lpu_pkg::PIPE_DEPTH) result_valid)
    else $error("request without result at fixed latency");

  // no result without a request the fixed latency earlier
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, lpu_pkg::PIPE_DEPTH))
    else $error("result without matching request");

  // batch marker travels with its particle
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.batch_end == $past(item.last_atom, lpu_pkg::PIPE_DEPTH)))
    else $error("batch marker out of step");

  // old x and z positions are the request positions, so data and valid stay aligned
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.old_pos_x == $past(item.pos_x, lpu_pkg::PIPE_DEPTH)
                      && result.old_pos_z == $past(item.pos_z, lpu_pkg::PIPE_DEPTH)))
    else $error("old position out of step");

endmodule

bind leapfrog_particle_update_unit lpu_checker u_lpu_checker (.*);
